// ===== rtl/ttsp_pkg.sv =====
// shared types and constants for the transposition table
`default_nettype none
package ttsp_pkg;
	localparam logic [1:0] FUNC_STORE = 2'd0;
	localparam logic [1:0] FUNC_PROBE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] BND_ALPHA  = 2'd1;
	localparam logic [1:0] BND_BETA   = 2'd2;
	localparam logic [1:0] BND_EXACT  = 2'd3;
	localparam int         PAY_W      = 58;
	localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         func;
		logic [63:0]        key;
		logic [24:0]        move_in;
		logic signed [15:0] score_in;
		logic [1:0]         bound_in;
		logic [6:0]         depth_in;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [7:0]         age_now;
		logic [7:0]         ply;
	} req_t;

	typedef struct packed {
		logic               found;
		logic               cutoff;
		logic [24:0]        move_out;
		logic signed [15:0] score_out;
		logic               stored;
		logic [31:0]        new_writes;
		logic [31:0]        over_writes;
		logic [31:0]        skipped_writes;
		logic [31:0]        hits;
	} rsp_t;

	typedef struct packed {
		logic [24:0]        move;
		logic signed [15:0] score;
		logic [1:0]         bound;
		logic [6:0]         depth;
		logic [7:0]         age;
	} slot_t;
endpackage
`default_nettype wire

// ===== rtl/ttsp_req_if.sv =====
// request and response channel interfaces
`default_nettype none
interface ttsp_req_if;
	logic          valid;
	logic          ready;
	ttsp_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ttsp_rsp_if;
	logic          valid;
	logic          ready;
	ttsp_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ttsp_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module ttsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/ttsp_front.sv =====
// input stage: accepts requests into a two-entry queue
`default_nettype none
module ttsp_front (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ttsp_req_if.sink   req,
	input  wire logic  deq,
	output      logic  avail,
	output ttsp_pkg::req_t head
);
	ttsp_pkg::req_t buf_q [2];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           enq;

	assign req.ready = (cnt_q != 2'd2);
	assign enq       = req.valid && req.ready;
	assign avail     = (cnt_q != 2'd0);
	assign head      = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			buf_q[wr_q] <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wr_q <= ~wr_q;
			if (deq) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end

`ifndef SYNTHESIS
	a_no_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> avail) else $error("dequeue from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !req.ready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

// ===== rtl/ttsp_back.sv =====
// table engine: read-modify-write per store or probe, clear sweep, counters
`default_nettype none
module ttsp_back #(
	parameter int ENTRIES = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  avail,
	input  wire ttsp_pkg::req_t head,
	output      logic  deq,
	ttsp_rsp_if.source rsp
);
	localparam int AW = $clog2(ENTRIES);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RMW  = 2'd1;
	localparam logic [1:0] ST_CLR  = 2'd2;

	logic [1:0]        st_q;
	logic [AW-1:0]     clr_q;
	ttsp_pkg::req_t    cur_q;
	logic [31:0]       cnew_q, cover_q, cskip_q, chit_q;
	logic              ovld_q;
	ttsp_pkg::rsp_t    out_q;

	logic              we;
	logic [AW-1:0]     addr;
	logic [63:0]       kw, kr;
	ttsp_pkg::slot_t   pw, pr;
	logic              can_go;

	assign can_go = !ovld_q || rsp.ready;
	assign deq    = (st_q == ST_IDLE) && avail && can_go;

	always_comb begin
		we   = 1'b0;
		addr = head.key[AW-1:0];
		kw   = cur_q.key;
		pw   = '{move: cur_q.move_in, score: cur_q.score_in, bound: cur_q.bound_in,
			depth: cur_q.depth_in, age: cur_q.ply};
		if (st_q == ST_CLR) begin
			we   = 1'b1;
			addr = clr_q;
			kw   = '0;
			pw   = '0;
		end else if (st_q == ST_RMW) begin
			addr = cur_q.key[AW-1:0];
			we   = (cur_q.func == ttsp_pkg::FUNC_STORE) &&
				((kr == 64'd0) || (cur_q.age_now > pr.age) || (cur_q.depth_in >= pr.depth) ||
				(cur_q.bound_in == ttsp_pkg::BND_EXACT && pr.bound != ttsp_pkg::BND_EXACT));
		end
	end

	ttsp_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_keys (
		.clk(clk), .we(we), .addr(addr), .wdata(kw), .rdata(kr));
	ttsp_ram #(.WIDTH(ttsp_pkg::PAY_W), .DEPTH(ENTRIES)) u_pay (
		.clk(clk), .we(we), .addr(addr), .wdata(pw), .rdata(pr));

	function automatic logic [31:0] sat(input logic [31:0] c);
		return (c == ttsp_pkg::CNT_MAX) ? c : c + 32'd1;
	endfunction

	// probe/store result computed from the read slot
	ttsp_pkg::rsp_t  r;
	logic [31:0]     nn, no, ns, nh;
	always_comb begin
		nn = cnew_q; no = cover_q; ns = cskip_q; nh = chit_q;
		r  = '0;
		if (cur_q.func == ttsp_pkg::FUNC_STORE) begin
			r.stored = we;
			if (kr == 64'd0) nn = sat(cnew_q);
			else if (we) no = sat(cover_q);
			else ns = sat(cskip_q);
		end else if (cur_q.func == ttsp_pkg::FUNC_PROBE && kr == cur_q.key) begin
			r.found    = 1'b1;
			r.move_out = pr.move;
			if (pr.depth >= cur_q.depth_in) begin
				nh          = sat(chit_q);
				r.score_out = pr.score;
				case (pr.bound)
					ttsp_pkg::BND_ALPHA: if (pr.score <= cur_q.alpha) begin
						r.score_out = cur_q.alpha; r.cutoff = 1'b1;
					end
					ttsp_pkg::BND_BETA: if (pr.score >= cur_q.beta) begin
						r.score_out = cur_q.beta; r.cutoff = 1'b1;
					end
					ttsp_pkg::BND_EXACT: r.cutoff = 1'b1;
					default: ;
				endcase
			end
		end
		r.new_writes = nn; r.over_writes = no; r.skipped_writes = ns; r.hits = nh;
	end

	always_ff @(posedge clk) begin
		if (deq) cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			cnew_q  <= '0; cover_q <= '0; cskip_q <= '0; chit_q <= '0;
			ovld_q  <= 1'b0;
			out_q   <= '0;
		end else begin
			if (ovld_q && rsp.ready) ovld_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (deq) begin
					if (head.func == ttsp_pkg::FUNC_CLEAR) begin
						st_q    <= ST_CLR;
						clr_q   <= '0;
						cnew_q  <= '0; cover_q <= '0; cskip_q <= '0; chit_q <= '0;
						out_q   <= '0;
						ovld_q  <= 1'b1;
					end else if (head.func == ttsp_pkg::FUNC_STORE ||
						head.func == ttsp_pkg::FUNC_PROBE) begin
						st_q <= ST_RMW;
					end else begin
						out_q <= '{found: 1'b0, cutoff: 1'b0, move_out: '0, score_out: '0,
							stored: 1'b0, new_writes: cnew_q, over_writes: cover_q,
							skipped_writes: cskip_q, hits: chit_q};
						ovld_q <= 1'b1;
					end
				end
				ST_RMW: begin
					out_q   <= r;
					ovld_q  <= 1'b1;
					cnew_q  <= nn; cover_q <= no; cskip_q <= ns; chit_q <= nh;
					st_q    <= ST_IDLE;
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ENTRIES - 1)) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = ovld_q;
	assign rsp.data  = out_q;

`ifndef SYNTHESIS
	a_rmw_one: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RMW) |=> (st_q == ST_IDLE && ovld_q)) else $error("rmw not finished");
	a_no_deq_busy: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> (st_q == ST_IDLE)) else $error("dequeue while busy");
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RMW) |=> (cnew_q >= $past(cnew_q))) else $error("counter went back");
`endif
endmodule
`default_nettype wire

// ===== rtl/transposition_table_store_probe.sv =====
// top level of the transposition table store and probe block
// Usage:
//   req channel carries one operation per beat: store, probe or clear.
//   rsp channel returns one result beat per request, in order, with the
//   four saturating counters as they stand after the operation.
//   Store and probe read the slot in one cycle and write or answer in the
//   next; as the slot memory has a single port, the engine takes no new
//   item until the last is through. A request waits in the queue; then a
//   store or probe result is registered after the slot read, and a clear
//   or unused code answer is registered as it is dequeued. Clear then
//   sweeps every slot, one per cycle, and no item is processed meanwhile.
//   After reset the same sweep runs before the first item is processed;
//   requests are still queued up to two deep meanwhile.
//   A two-entry queue decouples the input from the engine; when the
//   receiver stalls the result is held and the queue fills, then req.ready
//   drops. Reset is asynchronous, active low.
//   ENTRIES must be a power of two.
`default_nettype none
module transposition_table_store_probe #(
	parameter int ENTRIES = 4096
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ttsp_req_if.sink    req,
	ttsp_rsp_if.source  rsp
);
	logic           avail, deq;
	ttsp_pkg::req_t head;

	ttsp_front u_front (.clk(clk), .arst_n(arst_n), .req(req), .deq(deq),
		.avail(avail), .head(head));
	ttsp_back #(.ENTRIES(ENTRIES)) u_back (.clk(clk), .arst_n(arst_n), .avail(avail),
		.head(head), .deq(deq), .rsp(rsp));
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// testbench for the transposition table store and probe block
`timescale 1ns / 1ps
module tb_top;
	localparam int SLOTS = 4096;
	localparam int SWEEP_LIMIT = 20000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	ttsp_req_if req_ch();
	ttsp_rsp_if rsp_ch();

	transposition_table_store_probe #(.ENTRIES(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// shadow table
	logic [63:0]     tbl_key [SLOTS];
	ttsp_pkg::slot_t tbl_pay [SLOTS];
	logic [31:0]     n_new, n_over, n_skip, n_hit;

	ttsp_pkg::req_t pending_ops [$];
	ttsp_pkg::rsp_t expected_rsps [$];

	int  errors = 0;
	int  mismatches = 0;
	bit  gaps_on = 1;
	bit  hold_rsp = 0;
	bit  src_pause = 0;
	int  stuck_cycles = 0;

	function automatic logic [31:0] bump(logic [31:0] c);
		return (c == ttsp_pkg::CNT_MAX) ? c : c + 32'd1;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_pay[i] = '0;
		end
		n_new = '0;
		n_over = '0;
		n_skip = '0;
		n_hit = '0;
	endfunction

	function automatic ttsp_pkg::rsp_t predict_lookup(ttsp_pkg::req_t op);
		ttsp_pkg::rsp_t r;
		int idx;
		logic signed [15:0] sc;
		r = '0;
		idx = int'(op.key % 64'(SLOTS));
		if (op.func == ttsp_pkg::FUNC_STORE) begin
			bit wr;
			wr = 1;
			if (tbl_key[idx] == 64'd0)
				n_new = bump(n_new);
			else if (op.age_now > tbl_pay[idx].age || op.depth_in >= tbl_pay[idx].depth ||
				(op.bound_in == ttsp_pkg::BND_EXACT &&
				tbl_pay[idx].bound != ttsp_pkg::BND_EXACT))
				n_over = bump(n_over);
			else begin
				n_skip = bump(n_skip);
				wr = 0;
			end
			if (wr) begin
				tbl_key[idx] = op.key;
				tbl_pay[idx].move = op.move_in;
				tbl_pay[idx].score = op.score_in;
				tbl_pay[idx].bound = op.bound_in;
				tbl_pay[idx].depth = op.depth_in;
				tbl_pay[idx].age = op.ply;
				r.stored = 1'b1;
			end
		end else if (op.func == ttsp_pkg::FUNC_PROBE) begin
			if (tbl_key[idx] == op.key) begin
				r.found = 1'b1;
				r.move_out = tbl_pay[idx].move;
				if (tbl_pay[idx].depth >= op.depth_in) begin
					sc = tbl_pay[idx].score;
					n_hit = bump(n_hit);
					if (tbl_pay[idx].bound == ttsp_pkg::BND_ALPHA) begin
						if (sc <= op.alpha) begin
							sc = op.alpha;
							r.cutoff = 1'b1;
						end
					end else if (tbl_pay[idx].bound == ttsp_pkg::BND_BETA) begin
						if (sc >= op.beta) begin
							sc = op.beta;
							r.cutoff = 1'b1;
						end
					end else if (tbl_pay[idx].bound == ttsp_pkg::BND_EXACT)
						r.cutoff = 1'b1;
					r.score_out = sc;
				end
			end
		end else if (op.func == ttsp_pkg::FUNC_CLEAR)
			wipe_table();
		r.new_writes = n_new;
		r.over_writes = n_over;
		r.skipped_writes = n_skip;
		r.hits = n_hit;
		return r;
	endfunction

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_rsps.push_back(predict_lookup(req_ch.data));
				void'(pending_ops.pop_front());
			end
			// a waiting beat stays on the bus until taken
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap > 0)
					src_gap--;
				else if (gaps_on && $urandom_range(0, 9) == 0)
					src_gap = $urandom_range(1, 4);
				if (src_gap == 0 && !src_pause && pending_ops.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_ops[0];
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", rsp_ch.data);
				end else begin
					ttsp_pkg::rsp_t want;
					want = expected_rsps.pop_front();
					if (rsp_ch.data !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, rsp_ch.data);
					end
				end
			end
			if (sink_gap > 0)
				sink_gap--;
			else if (gaps_on && $urandom_range(0, 9) == 0)
				sink_gap = $urandom_range(1, 4);
			rsp_ch.ready <= (sink_gap == 0) && !hold_rsp;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || hold_rsp)
			stuck_cycles <= 0;
		else if (arst_n)
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles > SWEEP_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic ttsp_pkg::req_t rand_op(logic [1:0] f, logic [63:0] k);
		ttsp_pkg::req_t op;
		op.func = f;
		op.key = k;
		op.move_in = 25'($urandom);
		op.score_in = 16'($urandom);
		op.bound_in = 2'($urandom);
		op.depth_in = 7'($urandom);
		op.alpha = 16'($urandom);
		op.beta = 16'($urandom);
		op.age_now = 8'($urandom);
		op.ply = 8'($urandom);
		return op;
	endfunction

	function automatic logic [63:0] hot_key();
		// few keys per slot so stores collide and probes match
		logic [63:0] k;
		k = {10'd0, 2'($urandom_range(0, 3)), 52'd0} |
			(64'($urandom_range(0, 3)) << 12);
		return k | 64'($urandom_range(0, 15));
	endfunction

	task automatic drain();
		wait (pending_ops.size() == 0 && expected_rsps.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		ttsp_pkg::req_t op;
		arst_n = 1'b0;
		wipe_table();
		repeat (9) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed
		op = rand_op(ttsp_pkg::FUNC_PROBE, 64'd0); op.depth_in = 7'd0;
		pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_STORE, 64'd0); pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_STORE, '1); op.move_in = '1; op.score_in = 16'sh7FFF;
		op.bound_in = ttsp_pkg::BND_EXACT; op.depth_in = 7'd127; op.ply = 8'hFF;
		pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_PROBE, '1); op.depth_in = 7'd127;
		pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_STORE, '1); op.bound_in = ttsp_pkg::BND_ALPHA;
		op.depth_in = 7'd0; op.age_now = 8'd0; pending_ops.push_back(op);
		for (int b = 0; b < 4; b++) begin
			op = rand_op(ttsp_pkg::FUNC_STORE, 64'h55 + 64'(b)); op.bound_in = 2'(b);
			op.score_in = 16'sh8000; op.depth_in = 7'd10; pending_ops.push_back(op);
			op = rand_op(ttsp_pkg::FUNC_PROBE, 64'h55 + 64'(b)); op.depth_in = 7'd10;
			op.alpha = 16'sh8000; op.beta = 16'sh8000; pending_ops.push_back(op);
			op = rand_op(ttsp_pkg::FUNC_PROBE, 64'h55 + 64'(b)); op.depth_in = 7'd11;
			pending_ops.push_back(op);
		end
		op = rand_op(ttsp_pkg::FUNC_PROBE, 64'h1055); pending_ops.push_back(op);
		op = rand_op(FUNC_UNUSED, 64'h55); pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_CLEAR, 64'h55); pending_ops.push_back(op);
		op = rand_op(ttsp_pkg::FUNC_PROBE, 64'h55); pending_ops.push_back(op);
		drain();

		// receiver holds off while the sender keeps offering
		for (int i = 0; i < 12; i++)
			pending_ops.push_back(rand_op(ttsp_pkg::FUNC_STORE, hot_key()));
		hold_rsp = 1;
		repeat (60) @(posedge clk);
		hold_rsp = 0;
		drain();

		// random, mostly store/probe on colliding keys
		for (int i = 0; i < 850; i++) begin
			int r;
			logic [1:0] f;
			r = $urandom_range(0, 999);
			f = (r < 3) ? ttsp_pkg::FUNC_CLEAR : (r < 13) ? FUNC_UNUSED :
				(r < 500) ? ttsp_pkg::FUNC_STORE : ttsp_pkg::FUNC_PROBE;
			op = rand_op(f, ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : hot_key());
			if ($urandom_range(0, 3) != 0)
				op.depth_in = 7'($urandom_range(0, 12));
			pending_ops.push_back(op);
			if (i == 300) begin
				wait (pending_ops.size() == 0);
				src_pause = 1;
				wait (expected_rsps.size() == 0);
				src_pause = 0;
			end
			if (i == 700) begin
				wait (pending_ops.size() == 0);
				gaps_on = 0;
			end
		end
		drain();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
